>>> rtl/npet_pkg.sv
// ----------------------------------------------------------------------------
// npet_pkg
// Shared types and constants for the next periodic event time block.
// ----------------------------------------------------------------------------
package npet_pkg;

  // Default width of the time fields, in bits.
  localparam int unsigned TIME_BITS_DEF = 48;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_CALC,
    S_UPD,
    S_EMIT
  } npet_state_t;

  // Status that the remainder unit returns to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } npet_rem_stat_t;

endpackage

>>> rtl/npet_rem_unit.sv
// ----------------------------------------------------------------------------
// npet_rem_unit
// Iterative restoring remainder unit, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module npet_rem_unit #(
  parameter int unsigned TIME_BITS = npet_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [TIME_BITS-1:0]        dividend,
  input  logic [TIME_BITS-1:0]        divisor,
  output logic [TIME_BITS-1:0]        remainder,
  output npet_pkg::npet_rem_stat_t    stat
);
  import npet_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] dvd_r, dvd_nxt;
  logic [TIME_BITS-1:0] div_r, div_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   rem_diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign rem_sh   = {rem_r, dvd_r[TIME_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(TIME_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_nxt = rem_diff[TIME_BITS] ? rem_sh[TIME_BITS-1:0] : rem_diff[TIME_BITS-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/next_periodic_event_time_core.sv
// ----------------------------------------------------------------------------
// next_periodic_event_time_core
// Earliest next firing tick over a list of periodic timers.
//
//   Channel  Direction  Ports                                      Handshake
//   in_      input      now_time, sample_start, sample_period,     valid/stall
//                       no_timer, last
//   out_     output     next_fire_tick                             valid/stall
//
// A timer request whose current time is at or past its start passes through
// S_PREP, S_DIV, S_CALC and S_UPD: the remainder unit retires one dividend bit
// per cycle. A timer that has not started yet skips S_DIV and S_CALC; an item
// without a timer stays in S_IDLE. The item marked last adds S_EMIT for the result.
// in_stall stays high until the current request has finished.
// Reset clears the running minimum and the result register's valid bit.
// A stalled result holds the block only when the next result is ready.
// ----------------------------------------------------------------------------
module next_periodic_event_time_core #(
  parameter int unsigned TIME_BITS = npet_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [TIME_BITS-1:0]        in_now_time,
  input  logic [TIME_BITS-1:0]        in_sample_start,
  input  logic [TIME_BITS-1:0]        in_sample_period,
  input  logic                        in_no_timer,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [TIME_BITS+1:0] out_next_fire_tick
);
  import npet_pkg::*;

  localparam int unsigned RES_W = TIME_BITS + 2;

  npet_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] now_r, start_r, period_r;
  logic                 no_timer_r, last_r;
  logic [RES_W-1:0]     t_r;
  logic [RES_W-1:0]     min_r;
  logic                 seen_r;
  logic                 out_valid_r;
  logic [RES_W-1:0]     out_data_r;

  logic                 in_fire;
  logic                 rem_start;
  logic                 load_start;
  logic                 load_sum;
  logic                 do_update;
  logic                 do_emit;
  logic                 now_before;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] rem;
  npet_rem_stat_t       rem_stat;

  assign in_fire    = in_valid && !in_stall;
  assign now_before = now_r < start_r;
  assign diff       = now_r - start_r;

  npet_rem_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (diff),
    .divisor   (period_r),
    .remainder (rem),
    .stat      (rem_stat)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_no_timer) begin
            state_nxt = S_PREP;
          end else if (in_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_PREP: state_nxt = now_before ? S_UPD : S_DIV;
      S_DIV: begin
        if (rem_stat.done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: state_nxt = S_UPD;
      S_UPD:  state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = 1'b1;
    rem_start  = 1'b0;
    load_start = 1'b0;
    load_sum   = 1'b0;
    do_update  = 1'b0;
    do_emit    = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_PREP: begin
        load_start = now_before;
        rem_start  = !now_before;
      end
      S_DIV:  ;
      S_CALC: load_sum = 1'b1;
      S_UPD:  do_update = 1'b1;
      S_EMIT: do_emit = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= 1'b0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_emit) begin
        out_valid_r <= 1'b1;
        seen_r      <= 1'b0;
        min_r       <= '0;
      end else begin
        if (out_valid_r && !out_stall) begin
          out_valid_r <= 1'b0;
        end
        if (do_update) begin
          seen_r <= 1'b1;
          if (!seen_r || t_r < min_r) begin
            min_r <= t_r;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r      <= in_now_time;
      start_r    <= in_sample_start;
      period_r   <= (in_sample_period == '0) ? TIME_BITS'(1) : in_sample_period;
      no_timer_r <= in_no_timer;
      last_r     <= in_last;
    end
    if (load_start) begin
      t_r <= RES_W'(start_r);
    end else if (load_sum) begin
      t_r <= RES_W'(now_r) + RES_W'(period_r) - RES_W'(rem);
    end
    if (do_emit) begin
      out_data_r <= seen_r ? min_r : '1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_fire_tick = $signed(out_data_r);

  // The remainder unit only reports completion while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == S_DIV))
    else $error("remainder done outside the divide state");

  // The remainder of a finished division is below the period.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && rem_stat.done) |-> (rem < period_r))
    else $error("remainder not below period");

  // While the sequencer waits on the divider, the divider is working.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_stat.busy || rem_stat.done))
    else $error("divide state without an active division");

  // A result load clears the timer history for the next list.
  assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> (!seen_r && out_valid_r))
    else $error("list state not cleared after result load");

  // An update always leaves a timer recorded, and a timer entry never skips it.
  assert property (@(posedge clk) disable iff (!rst_n)
    do_update |=> (seen_r || $past(last_r)))
    else $error("timer update lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> !no_timer_r)
    else $error("timer path entered for an item without a timer");

endmodule
